[hw/rtl/hav_pkg.sv]
package hav_pkg;

   localparam int AngW = 34;
   localparam int CoW = 34;
   localparam logic [33:0] QuarterU = 34'd1509949440;
   localparam logic [33:0] HalfU = 34'd3019898880;
   localparam logic [33:0] FullU = 34'd6039797760;
   localparam logic [32:0] DegToRadK = 33'd4797524517;
   localparam logic signed [CoW-1:0] GainInv = 34'sd652032874;
   localparam logic signed [CoW-1:0] OneQ30 = 34'sd1073741824;

   function automatic logic signed [CoW-1:0] atan_entry(input int i);
      logic signed [CoW-1:0] t;
      case (i)
         0: t = 34'sd843314857;
         1: t = 34'sd497837829;
         2: t = 34'sd263043837;
         3: t = 34'sd133525159;
         4: t = 34'sd67021687;
         5: t = 34'sd33543516;
         6: t = 34'sd16775851;
         7: t = 34'sd8388437;
         8: t = 34'sd4194283;
         9: t = 34'sd2097149;
         default: t = (i < 31) ? (34'sd1 <<< (30 - i)) : 34'sd0;
      endcase
      return t;
   endfunction

   function automatic logic signed [CoW-1:0] clamp_q30(input logic signed [CoW-1:0] v);
      logic signed [CoW-1:0] r;
      if (v < 0) r = '0;
      else if (v > OneQ30) r = OneQ30;
      else r = v;
      return r;
   endfunction

endpackage

[hw/rtl/haversine_distance.sv]
// Throughput: one request per cycle; every stage is a register slice and the whole
// chain advances when the output slot is free or empty (no bubbles, no loss).
// Sine/cosine and atan2 CORDICs and both square roots are unrolled one step per stage.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
module haversine_distance import hav_pkg::*; #(
   parameter int CORDIC_STAGES = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [30:0] start_lat, [62:31] start_lon, [93:63] target_lat, [125:94] target_lon
   input  logic [127:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [29:0] distance_nm
   output logic [31:0] rsp_tdata
);

   localparam int N = CORDIC_STAGES;
   localparam int SQ = 32;          // root steps, bits 62..0 step 2; radicand is at most 2^60
   localparam int RW = 62;

   // whole pipe advances together; a single output slot decouples the consumer
   logic adv;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage A: half angles, folding ----------------
   logic signed [31:0] lat1, lat2, lon1, lon2;
   assign lat1 = 32'(signed'(req_tdata[30:0]));
   assign lon1 = signed'(req_tdata[62:31]);
   assign lat2 = 32'(signed'(req_tdata[93:63]));
   assign lon2 = signed'(req_tdata[125:94]);

   function automatic logic [AngW-1:0] mag34(input logic signed [AngW-1:0] v);
      return (v < 0) ? AngW'(-v) : AngW'(v);
   endfunction

   function automatic logic [AngW-1:0] fold_half(input logic signed [AngW-1:0] h);
      logic [AngW-1:0] u;
      u = mag34(h);
      // |h| < 2*HalfU for these input ranges; one subtract suffices
      if (u >= HalfU) u = u - HalfU;
      if (u >= HalfU) u = u - HalfU;
      if (u > QuarterU) u = HalfU - u;
      return u;
   endfunction

   // u0: dlat, u1: dlon, u2: lat1, u3: lat2 ; neg flags for cos
   logic [3:0][AngW-1:0] ua_in, ua_ff;
   logic [1:0] nga_in, nga_ff;
   logic va_ff;

   always_comb begin
      logic [AngW-1:0] u;
      ua_in[0] = fold_half(AngW'(lat2) - AngW'(lat1));
      ua_in[1] = fold_half(AngW'(lon2) - AngW'(lon1));
      for (int k = 0; k < 2; k++) begin
         u = mag34(AngW'(k == 0 ? lat1 : lat2)) << 1;
         if (u >= FullU) u = u - FullU;
         if (u > HalfU) u = FullU - u;
         nga_in[k] = (u > QuarterU);
         if (u > QuarterU) u = HalfU - u;
         ua_in[2+k] = u;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (adv) va_ff <= req_tvalid;
      if (adv) begin
         ua_ff <= ua_in;
         nga_ff <= nga_in;
      end
   end

   // ---------------- stage B: degrees to radians Q30 ----------------
   logic [3:0][CoW-1:0] zb_ff;
   logic [1:0] ngb_ff;
   logic vb_ff;
   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else if (adv) vb_ff <= va_ff;
      if (adv) begin
         for (int k = 0; k < 4; k++)
            zb_ff[k] <= CoW'((67'(ua_ff[k]) * 67'(DegToRadK) + (67'd1 << 31)) >> 32);
         ngb_ff <= nga_ff;
      end
   end

   // ---------------- rotation CORDIC, four lanes ----------------
   logic signed [CoW-1:0] rx_ff [N+1][4];
   logic signed [CoW-1:0] ry_ff [N+1][4];
   logic signed [CoW-1:0] rz_ff [N+1][4];
   logic [1:0] rn_ff [N+1];
   logic rv_ff [N+1];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rx_ff[0][k] = GainInv;
         ry_ff[0][k] = '0;
         rz_ff[0][k] = signed'(zb_ff[k]);
      end
      rn_ff[0] = ngb_ff;
      rv_ff[0] = vb_ff;
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (reset) rv_ff[i+1] <= 1'b0;
         else if (adv) rv_ff[i+1] <= rv_ff[i];
         if (adv) begin
            rn_ff[i+1] <= rn_ff[i];
            for (int k = 0; k < 4; k++) begin
               if (rz_ff[i][k] >= 0) begin
                  rx_ff[i+1][k] <= rx_ff[i][k] - (ry_ff[i][k] >>> i);
                  ry_ff[i+1][k] <= ry_ff[i][k] + (rx_ff[i][k] >>> i);
                  rz_ff[i+1][k] <= rz_ff[i][k] - atan_entry(i);
               end else begin
                  rx_ff[i+1][k] <= rx_ff[i][k] + (ry_ff[i][k] >>> i);
                  ry_ff[i+1][k] <= ry_ff[i][k] - (rx_ff[i][k] >>> i);
                  rz_ff[i+1][k] <= rz_ff[i][k] + atan_entry(i);
               end
            end
         end
      end
   end

   // ---------------- stage C: squares and cosine product ----------------
   logic signed [CoW-1:0] s0, s1, c2, c3;
   assign s0 = clamp_q30(ry_ff[N][0]);
   assign s1 = clamp_q30(ry_ff[N][1]);
   assign c2 = rn_ff[N][0] ? -clamp_q30(rx_ff[N][2]) : clamp_q30(rx_ff[N][2]);
   assign c3 = rn_ff[N][1] ? -clamp_q30(rx_ff[N][3]) : clamp_q30(rx_ff[N][3]);

   logic signed [CoW-1:0] slat_ff, slon_ff, cc_ff;
   logic vc_ff;
   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else if (adv) vc_ff <= rv_ff[N];
      if (adv) begin
         slat_ff <= CoW'((64'(s0) * 64'(s0) + (64'sd1 <<< 29)) >>> 30);
         slon_ff <= CoW'((64'(s1) * 64'(s1) + (64'sd1 <<< 29)) >>> 30);
         cc_ff <= CoW'((64'(c2) * 64'(c3) + (64'sd1 <<< 29)) >>> 30);
      end
   end

   // ---------------- stage D: cross term ----------------
   logic signed [CoW-1:0] slat_d_ff, term_ff;
   logic vd_ff;
   always_ff @(posedge clock) begin
      if (reset) vd_ff <= 1'b0;
      else if (adv) vd_ff <= vc_ff;
      if (adv) begin
         slat_d_ff <= slat_ff;
         term_ff <= CoW'((64'(cc_ff) * 64'(slon_ff) + (64'sd1 <<< 29)) >>> 30);
      end
   end

   // ---------------- stage E: clamp a, radicands ----------------
   logic [RW-1:0] ra_ff, rb_ff;
   logic ve_ff;
   always_ff @(posedge clock) begin
      logic signed [CoW-1:0] a;
      a = clamp_q30(slat_d_ff + term_ff);
      if (reset) ve_ff <= 1'b0;
      else if (adv) ve_ff <= vd_ff;
      if (adv) begin
         ra_ff <= RW'(a[30:0]) << 30;
         rb_ff <= RW'(31'(OneQ30 - a)) << 30;
      end
   end

   // ---------------- two square roots, one bit pair per stage ----------------
   logic [1:0][RW-1:0] qv_ff [SQ+1];
   logic [1:0][RW-1:0] qr_ff [SQ+1];
   logic qvld_ff [SQ+1];
   always_comb begin
      qv_ff[0][0] = ra_ff;
      qv_ff[0][1] = rb_ff;
      qr_ff[0] = '0;
      qvld_ff[0] = ve_ff;
   end

   for (genvar j = 0; j < SQ; j++) begin : g_sqrt
      localparam logic [RW-1:0] Bit = RW'(64'd1 << (2 * (SQ - 1 - j)));
      always_ff @(posedge clock) begin
         if (reset) qvld_ff[j+1] <= 1'b0;
         else if (adv) qvld_ff[j+1] <= qvld_ff[j];
         if (adv) begin
            for (int k = 0; k < 2; k++) begin
               if (qv_ff[j][k] >= qr_ff[j][k] + Bit) begin
                  qv_ff[j+1][k] <= qv_ff[j][k] - (qr_ff[j][k] + Bit);
                  qr_ff[j+1][k] <= (qr_ff[j][k] >> 1) + Bit;
               end else begin
                  qv_ff[j+1][k] <= qv_ff[j][k];
                  qr_ff[j+1][k] <= qr_ff[j][k] >> 1;
               end
            end
         end
      end
   end

   // ---------------- vectoring CORDIC ----------------
   logic signed [CoW-1:0] vx_ff [N+1];
   logic signed [CoW-1:0] vy_ff [N+1];
   logic signed [CoW-1:0] vz_ff [N+1];
   logic vv_ff [N+1];
   always_comb begin
      vy_ff[0] = CoW'(qr_ff[SQ][0]);
      vx_ff[0] = CoW'(qr_ff[SQ][1]);
      vz_ff[0] = '0;
      vv_ff[0] = qvld_ff[SQ];
   end

   for (genvar i = 0; i < N; i++) begin : g_vec
      always_ff @(posedge clock) begin
         if (reset) vv_ff[i+1] <= 1'b0;
         else if (adv) vv_ff[i+1] <= vv_ff[i];
         if (adv) begin
            if (vy_ff[i] > 0) begin
               vx_ff[i+1] <= vx_ff[i] + (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] - (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] + atan_entry(i);
            end else begin
               vx_ff[i+1] <= vx_ff[i] - (vy_ff[i] >>> i);
               vy_ff[i+1] <= vy_ff[i] + (vx_ff[i] >>> i);
               vz_ff[i+1] <= vz_ff[i] - atan_entry(i);
            end
         end
      end
   end

   // ---------------- scale: d = round(z*12742000 / (1852*2^14)) ----------------
   // 1852*2^14 = 463*2^16: estimate the quotient from p[54:24] times
   // M = floor(2^40/463), then correct it against the remainder.
   localparam logic [31:0] Radius2 = 32'd12742000;
   localparam logic [46:0] NmDen = 47'd30343168;
   localparam logic [31:0] RecipM = 32'd2374755135;    // floor(2^40 / 463)
   logic [55:0] p_ff;
   logic vp_ff;
   always_ff @(posedge clock) begin
      logic [30:0] z;
      z = (vz_ff[N] < 0) ? 31'd0 : vz_ff[N][30:0];
      if (reset) vp_ff <= 1'b0;
      else if (adv) vp_ff <= vv_ff[N];
      if (adv) p_ff <= 56'(z) * 56'(Radius2) + 56'(NmDen >> 1);
   end

   logic [55:0] p2_ff;
   logic [30:0] q_ff;
   logic vq_ff;
   always_ff @(posedge clock) begin
      if (reset) vq_ff <= 1'b0;
      else if (adv) vq_ff <= vp_ff;
      if (adv) begin
         q_ff <= 31'((63'(p_ff[54:24]) * 63'(RecipM)) >> 32);
         p2_ff <= p_ff;
      end
   end

   logic [29:0] d_ff;
   always_ff @(posedge clock) begin
      logic [56:0] rem;
      logic [31:0] q;
      rem = 57'(p2_ff) - 57'(q_ff) * 57'(NmDen);
      q = 32'(q_ff);
      // reciprocal underestimates by at most two
      if (rem >= 57'(NmDen)) begin
         rem = rem - 57'(NmDen);
         q = q + 32'd1;
      end
      if (rem >= 57'(NmDen)) q = q + 32'd1;
      if (reset) rsp_tvalid <= 1'b0;
      else if (adv) rsp_tvalid <= vq_ff;
      if (adv) d_ff <= (q > 32'h3FFFFFFF) ? 30'h3FFFFFFF : q[29:0];
   end

   assign rsp_tdata = {2'b00, d_ff};

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import hav_pkg::*;

   localparam int Stages = 24;
   localparam int Latency = 2 * Stages + 40;
   localparam longint OneQ = 64'sd1 << 30;
   localparam longint QuarterDeg = 64'd90 << 24;
   localparam longint HalfDeg = 64'd180 << 24;
   localparam longint FullDeg = 64'd360 << 24;
   localparam longint LatMax = 754974720;
   localparam longint LonMax = 1509949440;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   logic [29:0] expected_distance[$];
   int mismatches = 0;
   bit sink_idle_enable = 1'b1;
   bit source_idle_enable = 1'b1;

   haversine_distance #(.CORDIC_STAGES(Stages)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // atan(2^-i) in radians Q30
   function automatic longint arctan_step(input int i);
      longint t;
      case (i)
         0: t = 843314857;
         1: t = 497837829;
         2: t = 263043837;
         3: t = 133525159;
         4: t = 67021687;
         5: t = 33543516;
         6: t = 16775851;
         7: t = 8388437;
         8: t = 4194283;
         9: t = 2097149;
         default: t = (i < 31) ? (64'sd1 <<< (30 - i)) : 0;
      endcase
      return t;
   endfunction

   function automatic longint limit_unit(input longint v);
      return (v < 0) ? 0 : ((v > OneQ) ? OneQ : v);
   endfunction

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // rotate the gain vector by u (degrees * 2^24, folded into [0,90]); sine and cosine Q30
   function automatic void rotate_angle(input longint u, output longint sine,
                                        output longint cosine);
      longint z, x, y, xs, ys;
      logic [95:0] prod;
      prod = 96'(u) * 96'd4797524517 + 96'(64'd1 << 31);
      z = longint'(prod >> 32);
      x = 652032874;
      y = 0;
      for (int i = 0; i < Stages; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= arctan_step(i);
         end else begin
            x += ys; y -= xs; z += arctan_step(i);
         end
      end
      sine = limit_unit(y);
      cosine = limit_unit(x);
   endfunction

   function automatic longint half_sine_squared(input longint h);
      longint u, s, c;
      u = magnitude(h) % HalfDeg;
      if (u > QuarterDeg) u = HalfDeg - u;
      rotate_angle(u, s, c);
      return (s * s + (64'sd1 << 29)) >>> 30;
   endfunction

   function automatic longint latitude_cosine(input longint lat);
      longint u, s, c;
      bit flip;
      flip = 1'b0;
      u = (magnitude(lat) * 2) % FullDeg;
      if (u > HalfDeg) u = FullDeg - u;
      if (u > QuarterDeg) begin
         flip = 1'b1;
         u = HalfDeg - u;
      end
      rotate_angle(u, s, c);
      return flip ? -c : c;
   endfunction

   function automatic longint floor_root(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint vector_angle(input longint y, input longint x);
      longint z, xs, ys;
      z = 0;
      for (int i = 0; i < Stages; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += arctan_step(i);
         end else begin
            x -= ys; y += xs; z -= arctan_step(i);
         end
      end
      return (z < 0) ? 0 : z;
   endfunction

   function automatic logic [29:0] great_circle_nm(input longint lat1, input longint lon1,
                                                   input longint lat2, input longint lon2);
      longint slat, slon, cc, term, a, sa, sb, z, d;
      slat = half_sine_squared(lat2 - lat1);
      slon = half_sine_squared(lon2 - lon1);
      cc = (latitude_cosine(lat1) * latitude_cosine(lat2) + (64'sd1 << 29)) >>> 30;
      term = (cc * slon + (64'sd1 << 29)) >>> 30;
      a = limit_unit(slat + term);
      sa = floor_root(64'(a) << 30);
      sb = floor_root(64'(OneQ - a) << 30);
      z = vector_angle(sa, sb);
      d = (z * 12742000 + (1852 * 16384) / 2) / (1852 * 16384);
      if (d > 64'h3FFFFFFF) d = 64'h3FFFFFFF;
      return d[29:0];
   endfunction

   // send one position pair; predict its distance at acceptance
   task automatic send_request(input longint lat1, input longint lon1,
                               input longint lat2, input longint lon2);
      if (source_idle_enable) begin
         while ($urandom_range(99) < 29) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, lon2[31:0], lat2[30:0], lon1[31:0], lat1[30:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_distance.push_back(great_circle_nm(lat1, lon1, lat2, lon2));
   endtask

   // random idle on the result side
   always @(posedge clock) begin
      rsp_tready <= sink_idle_enable ? ($urandom_range(99) >= 29) : 1'b1;
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_distance.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d", rsp_tdata[29:0]);
         end else begin
            logic [29:0] want;
            want = expected_distance.pop_front();
            if (rsp_tdata[29:0] !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("distance_nm mismatch: expected %0d actual %0d",
                           want, rsp_tdata[29:0]);
            end
         end
      end
   end

   function automatic longint random_lat();
      return longint'($urandom_range(2 * LatMax)) - LatMax;
   endfunction

   function automatic longint random_lon();
      return longint'($urandom_range(32'(2 * LonMax))) - LonMax;
   endfunction

   // drop the request line and wait for every outstanding result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_distance.size() != 0) @(posedge clock);
   endtask

   // corners of the field ranges, poles, antipodes, equal points
   task automatic test_extremes();
      send_request(0, 0, 0, 0);
      send_request(LatMax, LonMax, -LatMax, -LonMax);
      send_request(-LatMax, -LonMax, LatMax, LonMax);
      send_request(LatMax, 0, -LatMax, 0);
      send_request(0, -LonMax, 0, LonMax);
      send_request(0, 0, 0, LonMax);
      send_request(0, -LonMax / 2, 0, LonMax / 2);
      send_request(LatMax, 123, LatMax, -99999);
      send_request(12345678, 8888, 12345678, 8888);
      send_request(-1, -1, 1, 1);
      send_request(0, 0, 1, 0);
      send_request(LatMax - 1, LonMax - 1, 1 - LatMax, 1 - LonMax);
      // latitudes past the pole and field-wide bit patterns
      send_request(-(64'sd1 << 30), -(64'sd1 << 31), (64'sd1 << 30) - 1, (64'sd1 << 31) - 1);
      send_request((64'sd1 << 30) - 1, (64'sd1 << 31) - 1, -(64'sd1 << 30), -(64'sd1 << 31));
      send_request(LatMax + 5000000, 0, LatMax, 1000);
      send_request(419430400, 100, -419430399, LonMax);
   endtask

   task automatic test_random_sweep(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(19) == 0)
            send_request(longint'($signed(31'($urandom()))), longint'($signed($urandom())),
                         longint'($signed(31'($urandom()))), longint'($signed($urandom())));
         else
            send_request(random_lat(), random_lon(), random_lat(), random_lon());
      end
   endtask

   // nearby points: small differences stress the clamp and small angles
   task automatic test_short_hops(input int count);
      longint lat, lon;
      for (int n = 0; n < count; n++) begin
         lat = random_lat();
         lon = random_lon();
         send_request(lat, lon, lat + $urandom_range(2000) - 1000,
                      lon + $urandom_range(2000) - 1000);
      end
   endtask

   // full rate on both sides
   task automatic test_back_to_back(input int count);
      source_idle_enable = 1'b0;
      sink_idle_enable = 1'b0;
      test_random_sweep(count);
      wait_drained();
      source_idle_enable = 1'b1;
      sink_idle_enable = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      wait_drained();
      test_random_sweep(400);
      test_short_hops(150);
      test_back_to_back(200);
      test_random_sweep(50);
      wait_drained();
      repeat (Latency + 20) @(posedge clock);
      if (mismatches == 0 && expected_distance.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #(4_000_000);
      $display("Some tests failed");
      $finish;
   end

endmodule
